FILE: hw/rtl/wtpm_pkg.sv
// Package for the wildcard token pattern matcher.
// Holds field widths, opcodes and the cell payload types shared by the cell chain and top level.
// No dependencies.
`default_nettype none

package wtpm_pkg;

    localparam int OPCODE_W        = 2;
    localparam int VALUE_W         = 63;
    localparam int COORD_W         = 32;
    localparam int MAX_PATTERN_DEF = 16;

    localparam logic [COORD_W-1:0] COORD_MAX = '1;
    localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(1);

    typedef enum logic [OPCODE_W-1:0] {
        OP_PATTERN = 2'd0,
        OP_TOKEN   = 2'd1,
        OP_EOL     = 2'd2
    } opcode_t;

    typedef struct packed {
        logic               wild;
        logic [VALUE_W-1:0] value;
    } pat_elem_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COORD_W-1:0] line;
        logic [COORD_W-1:0] column;
    } win_elem_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wtpm_cell.sv
// One cell of the matcher chain: one pattern element and one window token.
// Compares the two and passes both to its right-hand neighbor on shift.
// Depends on wtpm_pkg.
`default_nettype none

module wtpm_cell (
    input  wire                  aclk,
    input  wire                  pat_shift,
    input  wtpm_pkg::pat_elem_t  pat_in,
    output wtpm_pkg::pat_elem_t  pat_out,
    input  wire                  win_shift,
    input  wtpm_pkg::win_elem_t  win_in,
    output wtpm_pkg::win_elem_t  win_out,
    output logic                 hit
);
    import wtpm_pkg::*;

    pat_elem_t pat_reg;
    win_elem_t win_reg;

    always_ff @(posedge aclk) begin
        if (pat_shift) begin
            pat_reg <= pat_in;
        end
        if (win_shift) begin
            win_reg <= win_in;
        end
    end

    assign pat_out = pat_reg;
    assign win_out = win_reg;
    assign hit     = pat_reg.wild || (pat_reg.value == win_reg.value);

endmodule

`default_nettype wire

FILE: hw/rtl/wildcard_token_pattern_matcher.sv
// Wildcard token pattern matcher: top level with counters, cell chain and result register.
// Reports the line and column where each match of the stored pattern starts.
// Depends on wtpm_pkg and wtpm_cell.
//
// Usage:
//   Input channel s_*: opcode 0 appends a pattern element (s_is_wildcard marks
//   a wildcard), opcode 1 carries a text token in s_token_value, opcode 2 ends a
//   text line. Unused opcodes are taken and ignored. Elements beyond
//   MAX_PATTERN are dropped.
//   Result channel m_*: one item per match, line and column (1-based) of the
//   first token of the matching window, in text order.
//   Timing: a text token shifts the chain on the accept edge, and all MAX_PATTERN
//   cells compare in parallel in the following cycle, which loads the result
//   register on a match; s_ready is low in that compare cycle.
//   Stall: the result register holds while m_ready is low; new items are still
//   taken, except that a token whose evaluation finds a match waits in the
//   compare cycle until the result register frees.
//   Reset (aresetn low, synchronous): pattern and window empty, line and
//   column counters at 1, no result pending.
`default_nettype none

module wildcard_token_pattern_matcher #(
    parameter int MAX_PATTERN = wtpm_pkg::MAX_PATTERN_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire  [wtpm_pkg::OPCODE_W-1:0]   s_opcode,
    input  wire  [wtpm_pkg::VALUE_W-1:0]    s_token_value,
    input  wire                             s_is_wildcard,
    output logic                            m_valid,
    input  wire                             m_ready,
    output logic [wtpm_pkg::COORD_W-1:0]    m_match_line,
    output logic [wtpm_pkg::COORD_W-1:0]    m_match_column
);
    import wtpm_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

    logic               pend_reg, pend_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   seen_reg, seen_next;
    logic [COORD_W-1:0] line_reg, line_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic               m_valid_reg, m_valid_next;
    logic [COORD_W-1:0] m_line_reg, m_line_next;
    logic [COORD_W-1:0] m_col_reg, m_col_next;

    pat_elem_t pat_chain [MAX_PATTERN+1];
    win_elem_t win_chain [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] hit;
    logic [MAX_PATTERN-1:0] hit_ok;

    logic               accept;
    logic               pat_shift;
    logic               win_shift;
    logic               match;
    logic               out_free;
    logic [IDX_W-1:0]   start_idx;
    logic [COORD_W-1:0] start_line;
    logic [COORD_W-1:0] start_col;
    logic [LEN_W-1:0]   len_minus_one;

    assign s_ready   = !pend_reg;
    assign accept    = s_valid && s_ready;
    assign pat_shift = accept && (s_opcode == OP_PATTERN) && (len_reg < LEN_MAX);
    assign win_shift = accept && (s_opcode == OP_TOKEN);

    assign pat_chain[0].wild  = s_is_wildcard;
    assign pat_chain[0].value = s_is_wildcard ? '0 : s_token_value;
    assign win_chain[0].value  = s_token_value;
    assign win_chain[0].line   = line_reg;
    assign win_chain[0].column = col_reg;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        wtpm_cell u_cell (
            .aclk      (aclk),
            .pat_shift (pat_shift),
            .pat_in    (pat_chain[k]),
            .pat_out   (pat_chain[k+1]),
            .win_shift (win_shift),
            .win_in    (win_chain[k]),
            .win_out   (win_chain[k+1]),
            .hit       (hit[k])
        );
        assign hit_ok[k] = hit[k] || (LEN_W'(k) >= len_reg);
    end

    assign match         = (len_reg != '0) && (seen_reg >= len_reg) && (&hit_ok);
    assign len_minus_one = len_reg - LEN_W'(1);
    assign start_idx     = len_minus_one[IDX_W-1:0];

    always_comb begin
        start_line = '0;
        start_col  = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (IDX_W'(k) == start_idx) begin
                start_line = win_chain[k+1].line;
                start_col  = win_chain[k+1].column;
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        pend_next    = pend_reg;
        len_next     = len_reg;
        seen_next    = seen_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_line_next  = m_line_reg;
        m_col_next   = m_col_reg;

        if (pat_shift) begin
            len_next = len_reg + LEN_W'(1);
        end
        if (accept) begin
            case (s_opcode)
                OP_TOKEN: begin
                    pend_next = 1'b1;
                    col_next  = (col_reg == COORD_MAX) ? col_reg : col_reg + COORD_ONE;
                    if (seen_reg < LEN_MAX) begin
                        seen_next = seen_reg + LEN_W'(1);
                    end
                end
                OP_EOL: begin
                    line_next = (line_reg == COORD_MAX) ? line_reg : line_reg + COORD_ONE;
                    col_next  = COORD_ONE;
                end
                default: begin
                end
            endcase
        end

        if (pend_reg) begin
            if (!match) begin
                pend_next = 1'b0;
            end else if (out_free) begin
                pend_next    = 1'b0;
                m_valid_next = 1'b1;
                m_line_next  = start_line;
                m_col_next   = start_col;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            len_reg     <= '0;
            seen_reg    <= '0;
            line_reg    <= COORD_ONE;
            col_reg     <= COORD_ONE;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            len_reg     <= len_next;
            seen_reg    <= seen_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            m_valid_reg <= m_valid_next;
        end
        m_line_reg <= m_line_next;
        m_col_reg  <= m_col_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_match_line   = m_line_reg;
    assign m_match_column = m_col_reg;

`ifndef SYNTH
    a_token_starts_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        win_shift |=> pend_reg)
        else $error("token accepted without compare cycle");

    a_result_from_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid && !m_ready)) |-> ($past(pend_reg) && $past(match)))
        else $error("result loaded without a matching compare");

    a_counts_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_reg <= LEN_MAX) && (seen_reg <= LEN_MAX))
        else $error("pattern length or window fill beyond maximum");

    a_line_col_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (line_reg != '0) && (col_reg != '0))
        else $error("line or column counter wrapped to zero");
`endif

endmodule

`default_nettype wire
